// ===== rtl/rtw_pkg.sv =====
// Shared types, status codes and helpers for the radix to string converter.
package rtw_pkg;

  localparam int DEF_MAX_DIGITS = 64;
  localparam int VALUE_W = 64;
  localparam int SIZE_W = 16;
  localparam int RADIX_W = 8;
  localparam int CELL_W = 7;
  localparam int CHAR_W = 7;
  localparam int STATUS_W = 2;
  // Bits of the dividend consumed per division cycle.
  localparam int DIV_STEP = 8;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A_LESS_10 = 7'd87;

  // Classification made by the front end.
  typedef enum logic [1:0] {
    K_NO_BUFFER,
    K_SIZE_ONE,
    K_BAD_RADIX,
    K_CONVERT
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [SIZE_W-1:0]   size;
    logic [5:0]          radix;
  } cmd_t;

  // Digit value to its ASCII character, lower-case letters above nine.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d <= 6'd9) begin
      digit_char = CHAR_ZERO + dx;
    end else begin
      digit_char = CHAR_A_LESS_10 + dx;
    end
  endfunction

endpackage

// ===== rtl/rtw_if.sv =====
// Channel interfaces for the request and the cell write results.
interface rtw_in_if
  import rtw_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               buffer_present;
  logic [SIZE_W-1:0]  size;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, value, buffer_present, size, radix, input ready);
  modport sink (input valid, value, buffer_present, size, radix, output ready);
endinterface

interface rtw_out_if
  import rtw_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                write_enable;
  logic [CELL_W-1:0]   cell_index;
  logic [CHAR_W-1:0]   cell_char;
  logic                end_write;
  logic [CELL_W-1:0]   end_index;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, write_enable, cell_index, cell_char, end_write,
                  end_index, status, last, input ready);
  modport sink (input valid, write_enable, cell_index, cell_char, end_write,
                end_index, status, last, output ready);
endinterface

// ===== rtl/rtw_front.sv =====
// Front end: accepts requests and classifies them into commands.
module rtw_front
  import rtw_pkg::*;
(
  rtw_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output cmd_t   q_cmd
);

  // Accept whenever the command queue has room.
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;

  // Check buffer, then size, then radix, in that order.
  always_comb begin
    q_cmd.value = in_ch.value;
    q_cmd.size = in_ch.size;
    q_cmd.radix = in_ch.radix[5:0];
    if (!in_ch.buffer_present || in_ch.size == '0) begin
      q_cmd.kind = K_NO_BUFFER;
    end else if (in_ch.size == SIZE_W'(1)) begin
      q_cmd.kind = K_SIZE_ONE;
    end else if (in_ch.radix < RADIX_W'(2) || in_ch.radix > RADIX_W'(36)) begin
      q_cmd.kind = K_BAD_RADIX;
    end else begin
      q_cmd.kind = K_CONVERT;
    end
  end

endmodule

// ===== rtl/rtw_fifo.sv =====
// Two-entry command queue between the front and back ends.
module rtw_fifo
  import rtw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign pop_cmd = slots[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/rtw_back.sv =====
// Back end: digit generation by iterative division, then cell write output.
module rtw_back
  import rtw_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic q_pop,
  rtw_out_if.source out_ch
);

  localparam int NW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CHUNKS = VALUE_W / DIV_STEP;
  localparam int CW = $clog2(CHUNKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_SHOW,
    S_HOLD
  } state_t;

  state_t              state;
  logic [VALUE_W-1:0]  quo;
  logic [5:0]          rem;
  logic [5:0]          rdx;
  logic [CW-1:0]       chunk;
  logic [NW-1:0]       ndig;
  logic [NW-1:0]       idx;
  logic [NW-1:0]       ovsz;
  logic                ovf;
  logic                fin;
  logic [SIZE_W-1:0]   size_r;

  logic [CHAR_W-1:0]   digits [MAX_DIGITS];
  logic [CHAR_W-1:0]   rdata;
  logic [AW-1:0]       rd_addr;

  logic                ov;
  logic                o_we;
  logic [CELL_W-1:0]   o_idx;
  logic [CHAR_W-1:0]   o_char;
  logic                o_ew;
  logic [CELL_W-1:0]   o_eidx;
  logic [STATUS_W-1:0] o_st;
  logic                o_last;

  logic [VALUE_W-1:0]  quo_next;
  logic [5:0]          rem_next;
  logic [NW-1:0]       ndig_next;
  logic                xfer;

  assign out_ch.valid = ov;
  assign out_ch.write_enable = o_we;
  assign out_ch.cell_index = o_idx;
  assign out_ch.cell_char = o_char;
  assign out_ch.end_write = o_ew;
  assign out_ch.end_index = o_eidx;
  assign out_ch.status = o_st;
  assign out_ch.last = o_last;

  assign xfer = ov && out_ch.ready;
  assign q_pop = state == S_IDLE && !q_empty;
  assign ndig_next = ndig + NW'(1);

  // Eight restoring division steps on the top bits of the running dividend.
  always_comb begin
    logic [6:0] t;
    quo_next = quo;
    rem_next = rem;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {rem_next, quo_next[VALUE_W-1]};
      quo_next = {quo_next[VALUE_W-2:0], 1'b0};
      if (t >= {1'b0, rdx}) begin
        t = t - {1'b0, rdx};
        quo_next[0] = 1'b1;
      end
      rem_next = t[5:0];
    end
  end

  // Success reads the digits most significant first, overflow reads upward.
  always_comb begin
    if (ovf) begin
      rd_addr = AW'(idx);
    end else begin
      rd_addr = AW'(ndig - NW'(1) - idx);
    end
  end

  // Digit store, written one digit at a time, read data registered.
  always_ff @(posedge clk) begin
    if (state == S_DIV && chunk == CW'(CHUNKS - 1)) begin
      digits[AW'(ndig)] <= digit_char(rem_next);
    end
    rdata <= digits[rd_addr];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            quo <= q_cmd.value;
            rdx <= q_cmd.radix;
            size_r <= q_cmd.size;
            rem <= '0;
            chunk <= '0;
            ndig <= '0;
            o_we <= 1'b1;
            o_idx <= '0;
            o_char <= '0;
            o_ew <= 1'b0;
            o_eidx <= '0;
            o_last <= 1'b1;
            fin <= 1'b1;
            unique case (q_cmd.kind)
              K_NO_BUFFER: begin
                o_we <= 1'b0;
                o_st <= ST_INVALID;
                ov <= 1'b1;
                state <= S_HOLD;
              end
              K_SIZE_ONE: begin
                o_st <= ST_RANGE;
                ov <= 1'b1;
                state <= S_HOLD;
              end
              K_BAD_RADIX: begin
                o_st <= ST_INVALID;
                ov <= 1'b1;
                state <= S_HOLD;
              end
              K_CONVERT: begin
                state <= S_DIV;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV: begin
          quo <= quo_next;
          rem <= rem_next;
          chunk <= chunk + CW'(1);
          if (chunk == CW'(CHUNKS - 1)) begin
            rem <= '0;
            ndig <= ndig_next;
            if (quo_next == '0 || ndig_next == NW'(MAX_DIGITS)) begin
              // Decide between full fit and overflow.
              if ({{(SIZE_W + 1 - NW){1'b0}}, ndig_next} + (SIZE_W + 1)'(1)
                  <= {1'b0, size_r}) begin
                ovf <= 1'b0;
                idx <= '0;
              end else begin
                ovf <= 1'b1;
                idx <= NW'(1);
                ovsz <= NW'(size_r);
              end
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          o_we <= 1'b1;
          ov <= 1'b1;
          if (!ovf) begin
            o_idx <= CELL_W'(idx);
            o_char <= rdata;
            o_st <= ST_OK;
            o_ew <= idx == ndig - NW'(1);
            o_eidx <= (idx == ndig - NW'(1)) ? CELL_W'(ndig) : '0;
            o_last <= idx == ndig - NW'(1);
            fin <= idx == ndig - NW'(1);
          end else if (idx == ovsz) begin
            o_idx <= '0;
            o_char <= '0;
            o_st <= ST_RANGE;
            o_ew <= 1'b0;
            o_eidx <= '0;
            o_last <= 1'b1;
            fin <= 1'b1;
          end else begin
            o_idx <= CELL_W'(idx);
            o_char <= rdata;
            o_st <= ST_RANGE;
            o_ew <= 1'b0;
            o_eidx <= '0;
            o_last <= 1'b0;
            fin <= 1'b0;
          end
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (xfer) begin
            ov <= 1'b0;
            if (fin) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + NW'(1);
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/u64_radix_to_wide_string.sv =====
// Top level of the 64-bit unsigned integer to radix string converter.
//
//   Port     Role    Carries
//   in_ch    sink    value, buffer_present, size, radix (one conversion)
//   out_ch   source  one buffer cell write per transfer, last marks the end
//
// Division handles eight dividend bits per cycle, one digit per full pass
// over the 64-bit dividend. Each result is then read from the digit store,
// loaded into the output register and transferred, waiting while out_ch stalls.
// Error requests produce their single result straight from the idle state.
// Reset is synchronous; a stalled output holds the back end while the front
// end keeps queuing up to two requests.
module u64_radix_to_wide_string
  import rtw_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input logic clk,
  input logic rst,
  rtw_in_if.sink in_ch,
  rtw_out_if.source out_ch
);

  logic q_full;
  logic q_push;
  logic q_empty;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  rtw_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  rtw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  rtw_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
